// ----- src/block_normalized_correlation_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the block normalized correlation project
// Implication checks, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef BLOCK_NORMALIZED_CORRELATION_MACROS_SVH
`define BLOCK_NORMALIZED_CORRELATION_MACROS_SVH

`ifndef ASSERT_OFF
`define NCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ncc check failed");
`define NCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ncc check failed");
`else
`define NCC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define NCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/ncc_pkg.sv -----
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared constants, operation codes and control structs.
// ----------------------------------------------------------------------------
package ncc_pkg;

	localparam int PIXEL_BITS     = 8;
	localparam int DEF_MAX_PIXELS = 4096;
	localparam int Q_BITS         = 16;
	localparam int FRAC_BITS      = 15;
	localparam int BIT_IDX_BITS   = $clog2(Q_BITS);

	localparam logic [Q_BITS-1:0] Q_ONE = 16'h8000;
	localparam logic [Q_BITS-1:0] Q_MAX = 16'h7FFF;

	typedef enum logic [3:0] {
		OP_NA  = 4'd0,
		OP_SA2 = 4'd1,
		OP_NB  = 4'd2,
		OP_SB2 = 4'd3,
		OP_NAB = 4'd4,
		OP_SAB = 4'd5,
		OP_BL  = 4'd6,
		OP_C2  = 4'd7,
		OP_TT  = 4'd8,
		OP_BT  = 4'd9
	} mul_op_t;

	typedef struct packed {
		logic                    load;
		logic                    store;
		logic                    diff;
		logic                    emit;
		mul_op_t                 op;
		logic [BIT_IDX_BITS-1:0] bit_idx;
	} ncc_cmd_t;

	typedef struct packed {
		logic mul_zero;
		logic bad;
	} ncc_stat_t;

endpackage

// ----- src/ncc_mul.sv -----
// ----------------------------------------------------------------------------
// ncc_mul
// Shift-add multiplier, one multiplier bit per cycle, stops when the
// remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module ncc_mul #(
	parameter int PW = 114,
	parameter int MW = 41
) (
	input  logic          clk,
	input  logic          load,
	input  logic [PW-1:0] mcand_in,
	input  logic [MW-1:0] mplier_in,
	output logic [PW-1:0] prod,
	output logic          zero
);
	logic [PW-1:0] mcand_q;
	logic [MW-1:0] mplier_q;
	logic [PW-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (load) begin
			mcand_q  <= mcand_in;
			mplier_q <= mplier_in;
			acc_q    <= '0;
		end else if (mplier_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign prod = acc_q;
	assign zero = (mplier_q == '0);
endmodule

// ----- src/ncc_dpath.sv -----
// ----------------------------------------------------------------------------
// ncc_dpath
// Running sums, product registers and score formatting.
// ----------------------------------------------------------------------------
module ncc_dpath #(
	parameter int MAX_PIXELS = ncc_pkg::DEF_MAX_PIXELS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [ncc_pkg::PIXEL_BITS-1:0]  pixel_a,
	input  logic [ncc_pkg::PIXEL_BITS-1:0]  pixel_b,
	input  ncc_pkg::ncc_cmd_t               cmd,
	output ncc_pkg::ncc_stat_t              stat,
	output logic signed [ncc_pkg::Q_BITS-1:0] score,
	output logic                            score_valid,
	output logic                            done
);
	import ncc_pkg::*;

	localparam int CB  = $clog2(MAX_PIXELS + 1);
	localparam int SB  = PIXEL_BITS + CB - 1;
	localparam int SQB = 2 * PIXEL_BITS + CB - 1;
	localparam int VB  = CB + SQB;
	localparam int PW  = 2 * VB + 2 * Q_BITS;
	localparam int MW  = (VB > 2 * Q_BITS) ? VB : 2 * Q_BITS;

	logic [CB-1:0]  cnt_q;
	logic [SB-1:0]  sum_a_q, sum_b_q;
	logic [SQB-1:0] sum_aa_q, sum_bb_q, sum_ab_q;
	logic [SQB-1:0] a_ext, b_ext;

	logic [VB-1:0]     na_q, sa2_q, nb_q, sb2_q, nab_q, sab_q;
	logic [VB-1:0]     va_q, vb_q, cmag_q;
	logic              cneg_q, bad_q;
	logic [2*VB-1:0]   bl_q, c2_q;
	logic [2*Q_BITS-1:0] tt_q;
	logic [Q_BITS-1:0] q_q, t;

	logic [PW-1:0] mcand_in, prod;
	logic [MW-1:0] mplier_in;
	logic          mul_zero;
	logic [Q_BITS-1:0] q_lim, score_n;

	assign a_ext = SQB'(pixel_a);
	assign b_ext = SQB'(pixel_b);

	// accumulation; a full block ignores further pairs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			sum_aa_q <= '0;
			sum_bb_q <= '0;
			sum_ab_q <= '0;
		end else if (cmd.emit) begin
			cnt_q    <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			sum_aa_q <= '0;
			sum_bb_q <= '0;
			sum_ab_q <= '0;
		end else if (accept && (cnt_q < CB'(MAX_PIXELS))) begin
			cnt_q    <= cnt_q + CB'(1);
			sum_a_q  <= sum_a_q + SB'(pixel_a);
			sum_b_q  <= sum_b_q + SB'(pixel_b);
			sum_aa_q <= sum_aa_q + a_ext * a_ext;
			sum_bb_q <= sum_bb_q + b_ext * b_ext;
			sum_ab_q <= sum_ab_q + a_ext * b_ext;
		end
	end

	assign t = q_q | (Q_BITS'(1) << cmd.bit_idx);

	always_comb begin
		unique case (cmd.op)
			OP_NA:   begin mcand_in = PW'(sum_aa_q); mplier_in = MW'(cnt_q);   end
			OP_SA2:  begin mcand_in = PW'(sum_a_q);  mplier_in = MW'(sum_a_q); end
			OP_NB:   begin mcand_in = PW'(sum_bb_q); mplier_in = MW'(cnt_q);   end
			OP_SB2:  begin mcand_in = PW'(sum_b_q);  mplier_in = MW'(sum_b_q); end
			OP_NAB:  begin mcand_in = PW'(sum_ab_q); mplier_in = MW'(cnt_q);   end
			OP_SAB:  begin mcand_in = PW'(sum_a_q);  mplier_in = MW'(sum_b_q); end
			OP_BL:   begin mcand_in = PW'(va_q);     mplier_in = MW'(vb_q);    end
			OP_C2:   begin mcand_in = PW'(cmag_q);   mplier_in = MW'(cmag_q);  end
			OP_TT:   begin mcand_in = PW'(t);        mplier_in = MW'(t);       end
			OP_BT:   begin mcand_in = PW'(bl_q);     mplier_in = MW'(tt_q);    end
			default: begin mcand_in = '0;            mplier_in = '0;           end
		endcase
	end

	ncc_mul #(.PW(PW), .MW(MW)) u_mul (
		.clk       (clk),
		.load      (cmd.load),
		.mcand_in  (mcand_in),
		.mplier_in (mplier_in),
		.prod      (prod),
		.zero      (mul_zero)
	);

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			unique case (cmd.op)
				OP_NA:  na_q  <= prod[VB-1:0];
				OP_SA2: sa2_q <= prod[VB-1:0];
				OP_NB:  nb_q  <= prod[VB-1:0];
				OP_SB2: sb2_q <= prod[VB-1:0];
				OP_NAB: nab_q <= prod[VB-1:0];
				OP_SAB: sab_q <= prod[VB-1:0];
				OP_BL:  bl_q  <= prod[2*VB-1:0];
				OP_C2:  c2_q  <= prod[2*VB-1:0];
				OP_TT:  tt_q  <= prod[2*Q_BITS-1:0];
				OP_BT: begin
					// keep the trial bit while t^2 * va * vb <= 2^30 * cov^2
					if (prod <= PW'({c2_q, {(2*FRAC_BITS){1'b0}}})) begin
						q_q <= t;
					end
				end
				default: ;
			endcase
		end else if (cmd.diff) begin
			bad_q  <= (na_q <= sa2_q) || (nb_q <= sb2_q);
			va_q   <= na_q - sa2_q;
			vb_q   <= nb_q - sb2_q;
			cneg_q <= nab_q < sab_q;
			cmag_q <= (nab_q < sab_q) ? (sab_q - nab_q) : (nab_q - sab_q);
			q_q    <= '0;
		end
	end

	always_comb begin
		q_lim = (q_q > Q_ONE) ? Q_ONE : q_q;
		if (cneg_q) begin
			score_n = '0 - q_lim;
		end else begin
			score_n = (q_lim == Q_ONE) ? Q_MAX : q_lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			score       <= bad_q ? '0 : score_n;
			score_valid <= !bad_q;
		end
	end

	assign stat.mul_zero = mul_zero;
	assign stat.bad      = bad_q;
endmodule

// ----- src/ncc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ncc_ctrl
// Sequencer: runs the multiply schedule and the 16-step root search.
// ----------------------------------------------------------------------------
module ncc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               is_last,
	input  ncc_pkg::ncc_stat_t stat,
	output ncc_pkg::ncc_cmd_t  cmd,
	output logic               busy
);
	import ncc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_RUN   = 6'b000100,
		ST_DIFF  = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t                  state_q;
	mul_op_t                 op_q;
	logic [BIT_IDX_BITS-1:0] bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NA;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_last) begin
						state_q <= ST_LOAD;
						op_q    <= OP_NA;
					end
				end
				ST_LOAD: state_q <= ST_RUN;
				ST_RUN: begin
					if (stat.mul_zero) begin
						unique case (op_q)
							OP_NA: begin
								state_q <= ST_LOAD;
								op_q    <= OP_SA2;
							end
							OP_SA2: begin
								state_q <= ST_LOAD;
								op_q    <= OP_NB;
							end
							OP_NB: begin
								state_q <= ST_LOAD;
								op_q    <= OP_SB2;
							end
							OP_SB2: begin
								state_q <= ST_LOAD;
								op_q    <= OP_NAB;
							end
							OP_NAB: begin
								state_q <= ST_LOAD;
								op_q    <= OP_SAB;
							end
							OP_SAB: state_q <= ST_DIFF;
							OP_BL: begin
								state_q <= ST_LOAD;
								op_q    <= OP_C2;
							end
							OP_C2: begin
								state_q <= ST_LOAD;
								op_q    <= OP_TT;
								bit_q   <= BIT_IDX_BITS'(Q_BITS - 1);
							end
							OP_TT: begin
								state_q <= ST_LOAD;
								op_q    <= OP_BT;
							end
							OP_BT: begin
								if (bit_q == '0) begin
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_LOAD;
									op_q    <= OP_TT;
									bit_q   <= bit_q - BIT_IDX_BITS'(1);
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DIFF: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (stat.bad) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_LOAD;
						op_q    <= OP_BL;
					end
				end
				ST_OUT:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load    = (state_q == ST_LOAD);
		cmd.store   = (state_q == ST_RUN) && stat.mul_zero;
		cmd.diff    = (state_q == ST_DIFF);
		cmd.emit    = (state_q == ST_OUT);
		cmd.op      = op_q;
		cmd.bit_idx = bit_q;
	end

	assign busy = (state_q != ST_IDLE);
endmodule

// ----- src/block_normalized_correlation.sv -----
// ----------------------------------------------------------------------------
// block_normalized_correlation
// Zero-mean normalized cross-correlation of two pixel blocks, Q1.15 result.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pixel_a, pixel_b and is_last with start high; a pair is taken at
//   a clock edge where start is high and busy is low. Pairs are taken one
//   per cycle while the block sums. is_last marks the block's final pair.
//   After the final pair busy rises while the score is worked out by one
//   shared shift-add multiplier (one multiplier bit per cycle): six sum
//   products, a variance product and a covariance square, then sixteen
//   trial steps of the square-root search of two products each. If a
//   variance is not positive, all but the sum products are skipped and
//   the score is zero with score_valid low.
//   score and score_valid are then updated with done high, busy
//   falls in that same cycle, and the sums are already clear for the next
//   block. The receiver cannot stall; done is a single-cycle strobe.
//   Reset clears the sums and the count and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`include "block_normalized_correlation_macros.svh"

module block_normalized_correlation #(
	parameter int MAX_PIXELS = ncc_pkg::DEF_MAX_PIXELS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [ncc_pkg::PIXEL_BITS-1:0]     pixel_a,
	input  logic [ncc_pkg::PIXEL_BITS-1:0]     pixel_b,
	input  logic                               is_last,
	output logic                               done,
	output logic signed [ncc_pkg::Q_BITS-1:0]  score,
	output logic                               score_valid
);
	import ncc_pkg::*;

	logic      accept;
	ncc_cmd_t  cmd;
	ncc_stat_t stat;

	assign accept = start && !busy;

	ncc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.is_last (is_last),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	ncc_dpath #(.MAX_PIXELS(MAX_PIXELS)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel_a     (pixel_a),
		.pixel_b     (pixel_b),
		.cmd         (cmd),
		.stat        (stat),
		.score       (score),
		.score_valid (score_valid),
		.done        (done)
	);

	`NCC_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`NCC_ASSERT_NEXT(a_last_busy, clk, arst_n, accept && is_last, busy)
	`NCC_ASSERT_NEXT(a_pair_quiet, clk, arst_n, accept && !is_last, !done)
	`NCC_ASSERT_SAME(a_invalid_zero, clk, arst_n, done && !score_valid, score == '0)
endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for block_normalized_correlation: streams pixel-pair
// blocks, predicts each Q1.15 score with exact wide integer math and
// compares every done strobe against it.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ncc_pkg::*;

	localparam int PIX_MAX = (1 << PIXEL_BITS) - 1;

	typedef struct {
		logic signed [Q_BITS-1:0] score;
		logic                     valid;
	} corr_result_t;

	class corr_scoreboard;
		bit [12:0]          npairs;
		bit [19:0]          acc_a, acc_b;
		bit [27:0]          acc_aa, acc_bb, acc_ab;
		corr_result_t       pending[$];
		int                 errors;

		function void clear_sums();
			npairs = 0; acc_a = 0; acc_b = 0;
			acc_aa = 0; acc_bb = 0; acc_ab = 0;
		endfunction

		// accepted request: accumulate, and on the last pair predict the score
		function void note_pair(bit [PIXEL_BITS-1:0] a, bit [PIXEL_BITS-1:0] b, bit last);
			bit [63:0]    n, na, nb, nab, sa2, sb2, sab, va, vb, cmag;
			bit [127:0]   prod_v, prod_c, trial;
			bit [63:0]    q, t;
			bit           cneg;
			corr_result_t r;
			if (npairs < DEF_MAX_PIXELS) begin
				acc_a  += a;
				acc_b  += b;
				acc_aa += a * a;
				acc_bb += b * b;
				acc_ab += a * b;
				npairs += 1;
			end
			if (!last)
				return;
			n   = npairs;
			na  = n * acc_aa;
			nb  = n * acc_bb;
			nab = n * acc_ab;
			sa2 = 64'(acc_a) * acc_a;
			sb2 = 64'(acc_b) * acc_b;
			sab = 64'(acc_a) * acc_b;
			if (na <= sa2 || nb <= sb2) begin
				r.score = 0;
				r.valid = 0;
			end else begin
				va     = na - sa2;
				vb     = nb - sb2;
				cneg   = nab < sab;
				cmag   = cneg ? sab - nab : nab - sab;
				prod_v = 128'(va) * 128'(vb);
				prod_c = (128'(cmag) * 128'(cmag)) << 30;
				q = 0;
				for (int i = 15; i >= 0; i--) begin
					t     = q | (64'd1 << i);
					trial = 128'(t * t) * prod_v;
					if (trial <= prod_c)
						q = t;
				end
				if (q > 32768)
					q = 32768;
				if (cneg)
					r.score = 16'((65536 - q) & 16'hFFFF);
				else
					r.score = 16'((q > 32767) ? 32767 : q);
				r.valid = 1;
			end
			pending.push_back(r);
			clear_sums();
		endfunction

		function void check_score(logic signed [Q_BITS-1:0] s, logic v);
			corr_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected score %0d valid %0b", $realtime, s, v);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (s !== e.score) begin
				$display("%0t: score expected %0d actual %0d", $realtime, e.score, s);
				errors++;
			end
			if (v !== e.valid) begin
				$display("%0t: score_valid expected %0b actual %0b",
					$realtime, e.valid, v);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [PIXEL_BITS-1:0]       pixel_a;
	logic [PIXEL_BITS-1:0]       pixel_b;
	logic                        is_last;
	logic                        done;
	logic signed [Q_BITS-1:0]    score;
	logic                        score_valid;

	corr_scoreboard sb = new();
	bit             took;
	int             sent;
	bit             quiet;

	block_normalized_correlation u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel_a    (pixel_a),
		.pixel_b    (pixel_b),
		.is_last    (is_last),
		.done       (done),
		.score      (score),
		.score_valid(score_valid)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		took = arst_n && start && !busy;
		if (took)
			sb.note_pair(pixel_a, pixel_b, is_last);
		if (arst_n && done)
			sb.check_score(score, score_valid);
	end

	task automatic idle_burst();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			start = 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	// drive one request and hold it until the block takes it
	task automatic send_pair(int a, int b, bit last);
		idle_burst();
		start   = 1;
		pixel_a = a[PIXEL_BITS-1:0];
		pixel_b = b[PIXEL_BITS-1:0];
		is_last = last;
		do @(negedge clk); while (!took);
		sent++;
	endtask

	// mode: 0 random, 1 b = a, 2 b inverted, 3 flat a, 4 flat b
	task automatic send_block(int len, int mode);
		int a, b;
		int flat_v;
		flat_v = $urandom_range(0, PIX_MAX);
		for (int i = 0; i < len; i++) begin
			a = $urandom_range(0, PIX_MAX);
			b = $urandom_range(0, PIX_MAX);
			case (mode)
				1: b = a;
				2: b = PIX_MAX - a;
				3: a = flat_v;
				4: b = flat_v;
				default: ;
			endcase
			send_pair(a, b, i == len - 1);
		end
	endtask

	initial begin
		int len, mode;
		bit paused;
		start   = 0;
		pixel_a = 0;
		pixel_b = 0;
		is_last = 0;
		arst_n  = 0;
		quiet   = 0;
		paused  = 0;
		sb.clear_sums();
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, perfect and inverse match, flat and short blocks
		send_pair(0, 0, 0);
		send_pair(PIX_MAX, PIX_MAX, 1);
		send_pair(0, PIX_MAX, 0);
		send_pair(PIX_MAX, 0, 1);
		send_pair(PIX_MAX, PIX_MAX, 1);
		send_pair(0, 0, 0);
		send_pair(PIX_MAX, PIX_MAX, 0);
		send_pair(7, 7, 1);
		send_pair(3, 5, 0);
		send_pair(3, 9, 1);
		send_pair(1, 40, 0);
		send_pair(2, 40, 1);
		send_block(4, 2);
		send_block(5, 1);
		// block longer than the pair limit: extra pairs are dropped
		send_block(DEF_MAX_PIXELS + 5, 0);

		while (sent < 2000 + DEF_MAX_PIXELS) begin
			if (sent > 1700 + DEF_MAX_PIXELS)
				quiet = 1;
			if (!paused && sent > 800 + DEF_MAX_PIXELS) begin
				start  = 0;
				paused = 1;
				while (sb.pending.size() != 0) @(negedge clk);
			end
			case ($urandom_range(0, 19))
				0:       len = 1;
				1:       len = $urandom_range(17, 80);
				default: len = $urandom_range(2, 16);
			endcase
			mode = $urandom_range(0, 9);
			send_block(len, mode > 4 ? 0 : mode);
		end
		start = 0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (1100) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#800ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
